FILE: design/ctfr_pkg.sv
// Shared types and codes for the CAN transport frame reassembler.
// No dependencies; every other design file imports this package.
package ctfr_pkg;

    // Widths fixed by the frame and result formats
    localparam int FRAME_BYTES   = 8;
    localparam int SEG_BYTES     = 7;
    localparam int LEN_W         = 4;
    localparam int TOTAL_W       = 12;
    localparam int COUNT_W       = 13;
    localparam int SEQ_W         = 4;
    localparam int CNT_W         = 3;
    localparam int EVENT_W       = 3;
    localparam int IN_TDATA_W    = 72;
    localparam int OUT_TDATA_W   = 88;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Protocol control nibble of byte 0
    localparam logic [3:0] PCI_SINGLE      = 4'h0;
    localparam logic [3:0] PCI_FIRST       = 4'h1;
    localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_IGNORED  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_SINGLE   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_FIRST_FC = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SEGMENT  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_SEQ_ERR  = 3'd4;

    // One received frame; data[0] is byte 0 in the lowest bits
    typedef struct packed {
        logic [LEN_W-1:0]                 frame_length;
        logic [FRAME_BYTES-1:0][7:0]      data;
    } t_frame;

    // Packed as on the output tdata, offset in the lowest bits
    typedef struct packed {
        logic [TOTAL_W-1:0]               total_length;
        logic [SEG_BYTES-1:0][7:0]        seg;
        logic [CNT_W-1:0]                 byte_count;
        logic [COUNT_W-1:0]               offset;
    } t_payload;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic               message_done;
        t_payload           payload;
    } t_result;

endpackage

FILE: design/ctfr_in_stage.sv
// Input register stage of the frame reassembler.
// Depends on ctfr_pkg for the frame type.
module ctfr_in_stage
    import ctfr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_frame i_frame,
    input  logic   i_advance,
    output logic   o_ready,
    output logic   o_valid,
    output t_frame o_frame
);

    logic   r_valid;
    t_frame r_frame;

    // accept when empty or when the held frame moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_frame <= i_frame;
        end
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;

endmodule

FILE: design/ctfr_decode.sv
// Frame classifier and reassembly state (total, count, sequence).
// Depends on ctfr_pkg for frame and result types and codes.
module ctfr_decode
    import ctfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_enable,
    input  t_frame  i_frame,
    output t_result o_result
);

    logic [TOTAL_W-1:0] r_expected_total, n_expected_total;
    logic [COUNT_W-1:0] r_received_count, n_received_count;
    logic [SEQ_W-1:0]   r_next_sequence,  n_next_sequence;

    logic [3:0]         kind;
    logic [3:0]         low;
    logic [LEN_W-1:0]   sf_limit;
    logic [3:0]         sf_len;
    logic [COUNT_W:0]   cf_sum;
    logic [SEG_BYTES-1:0][7:0] raw_seg;
    t_result            res;

    assign kind = i_frame.data[0][7:4];
    assign low  = i_frame.data[0][3:0];

    always_comb begin
        n_expected_total = r_expected_total;
        n_received_count = r_received_count;
        n_next_sequence  = r_next_sequence;
        res              = '0;
        raw_seg          = '0;
        sf_limit         = (i_frame.frame_length == '0) ? '0 : i_frame.frame_length - 1'b1;
        sf_len           = (low > sf_limit) ? sf_limit : low;
        if (sf_len > 4'd7) begin
            sf_len = 4'd7;
        end
        cf_sum           = {1'b0, r_received_count} + (COUNT_W+1)'(SEG_BYTES);

        unique case (kind)
            PCI_SINGLE: begin
                res.event_res                   = EV_SINGLE;
                res.message_done                = 1'b1;
                res.payload.byte_count          = sf_len[CNT_W-1:0];
                res.payload.total_length        = TOTAL_W'(sf_len);
                for (int i = 0; i < SEG_BYTES; i++) begin
                    raw_seg[i] = i_frame.data[i+1];
                end
            end
            PCI_FIRST: begin
                n_expected_total                = {low, i_frame.data[1]};
                n_received_count                = COUNT_W'(6);
                n_next_sequence                 = SEQ_W'(1);
                res.event_res                   = EV_FIRST_FC;
                res.payload.byte_count          = CNT_W'(6);
                res.payload.total_length        = {low, i_frame.data[1]};
                for (int i = 0; i < SEG_BYTES - 1; i++) begin
                    raw_seg[i] = i_frame.data[i+2];
                end
            end
            PCI_CONSECUTIVE: begin
                if (low != r_next_sequence) begin
                    // drop the message in progress, report the bad control byte
                    n_expected_total = '0;
                    n_received_count = '0;
                    res.event_res    = EV_SEQ_ERR;
                    raw_seg[0]       = i_frame.data[0];
                end else begin
                    n_next_sequence  = (r_next_sequence == '1) ? SEQ_W'(1)
                                                               : r_next_sequence + 1'b1;
                    n_received_count = (cf_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                                    : cf_sum[COUNT_W-1:0];
                    res.event_res            = EV_SEGMENT;
                    res.message_done         = (n_received_count >= {1'b0, r_expected_total});
                    res.payload.offset       = r_received_count;
                    res.payload.byte_count   = CNT_W'(SEG_BYTES);
                    res.payload.total_length = r_expected_total;
                    for (int i = 0; i < SEG_BYTES; i++) begin
                        raw_seg[i] = i_frame.data[i+1];
                    end
                end
            end
            default: begin
                res.event_res = EV_IGNORED;
            end
        endcase

        // zero seg bytes past the count; a sequence error still carries seg0
        for (int i = 0; i < SEG_BYTES; i++) begin
            if ((CNT_W+1)'(i) < {1'b0, res.payload.byte_count}
                    || (i == 0 && res.event_res == EV_SEQ_ERR)) begin
                res.payload.seg[i] = raw_seg[i];
            end else begin
                res.payload.seg[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_total <= '0;
            r_received_count <= '0;
            r_next_sequence  <= '0;
        end else if (i_enable) begin
            r_expected_total <= n_expected_total;
            r_received_count <= n_received_count;
            r_next_sequence  <= n_next_sequence;
        end
    end

    assign o_result = res;

endmodule

FILE: design/can_transport_frame_reassembler_unit.sv
// Top level of the CAN transport frame reassembler.
// Depends on ctfr_pkg, ctfr_in_stage and ctfr_decode.
//
// Usage:
//   Slave channel (s_axis) takes one received CAN frame per item: eight
//   data bytes and the frame length. Master channel (m_axis) gives one
//   result per frame: the event kind on tuser, the payload segment with
//   its message offset, byte count and declared total on tdata, and
//   tlast when the segment completes a message.
//   Frames are classified by the control nibble of byte 0: single frame,
//   first frame (answer with clear-to-send flow control), consecutive
//   frame, or ignored. A wrong sequence number reports an error item and
//   drops the message in progress. Payload is streamed, not buffered.
//   Path: each frame is held in the input register, then its result is
//   held in the result register. Throughput: one item per cycle while
//   m_axis_tready is high; the decode and the counter update sit in one
//   register-to-register path, so back-to-back frames see each other's
//   state updates.
//   Stall: when m_axis_tready is low the result register holds, one more
//   frame waits in the input register, and s_axis_tready then drops.
//   Reset (synchronous, active low) empties both registers and clears
//   the expected total, received count and expected sequence to zero.
module can_transport_frame_reassembler_unit
    import ctfr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // byte0[7:0], byte1..byte7, frame_length[67:64], zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // offset[12:0], byte_count[15:13], seg0..seg6[71:16], total_length[83:72], zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // event_res[2:0]
    output logic [EVENT_W-1:0]     o_m_axis_tuser,
    // message_done
    output logic                   o_m_axis_tlast
);

    logic    in_valid;
    logic    advance;
    t_frame  in_frame;
    t_result dec_result;
    logic    r_out_valid;
    t_result r_out;

    // move the held frame into the result register when it is free
    assign advance = in_valid && (!r_out_valid || i_m_axis_tready);

    ctfr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_frame   (t_frame'(i_s_axis_tdata[$bits(t_frame)-1:0])),
        .i_advance (advance),
        .o_ready   (o_s_axis_tready),
        .o_valid   (in_valid),
        .o_frame   (in_frame)
    );

    // state advances exactly when the frame's result is captured
    ctfr_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (advance),
        .i_frame  (in_frame),
        .o_result (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid <= in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= dec_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - $bits(t_payload))'(0), r_out.payload};
    assign o_m_axis_tuser  = r_out.event_res;
    assign o_m_axis_tlast  = r_out.message_done;

endmodule

FILE: design/ctfr_checker.sv
// Port-level checks for the frame reassembler, bound to the top level.
// Depends on ctfr_pkg and can_transport_frame_reassembler_unit.
module ctfr_checker
    import ctfr_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] i_m_axis_tdata,
    input logic [EVENT_W-1:0]     i_m_axis_tuser,
    input logic                   i_m_axis_tlast
);

    // hold a stalled result
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid)
        else $error("result dropped while stalled");

    // only single frames and in-sequence segments complete a message
    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tlast |->
            i_m_axis_tuser == EV_SINGLE || i_m_axis_tuser == EV_SEGMENT)
        else $error("message_done on a non-payload event");

    // a sequence error carries no count, offset or total
    a_seq_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tuser == EV_SEQ_ERR |->
            i_m_axis_tdata[15:0] == 16'h0 && i_m_axis_tdata[83:72] == 12'h0)
        else $error("sequence error with payload fields");

    // a segment that follows a segment starts seven bytes later, unless saturated
    a_offset_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tready && i_m_axis_tuser == EV_SEGMENT
            && i_m_axis_tdata[12:0] < 13'd8184
        ##1 i_m_axis_tvalid && i_m_axis_tuser == EV_SEGMENT
        |-> i_m_axis_tdata[12:0] == $past(i_m_axis_tdata[12:0]) + 13'd7)
        else $error("segment offset did not advance by seven");

endmodule

bind can_transport_frame_reassembler_unit ctfr_checker u_ctfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

FILE: verif/testbench.sv
// Testbench for can_transport_frame_reassembler_unit: drives CAN frames on the
// slave stream and checks each result against a scoreboard predictor.
// Depends on ctfr_pkg and the reassembler RTL only.
module testbench;
    import ctfr_pkg::*;

    // Scoreboard: mirrors the message in progress and queues one expected
    // segment result per accepted frame.
    class segment_scoreboard;
        logic [TOTAL_W-1:0] msg_total;
        logic [COUNT_W-1:0] bytes_seen;
        logic [SEQ_W-1:0]   want_seq;
        t_result            pending_segments[$];
        int                 errors;

        function new();
            msg_total  = '0;
            bytes_seen = '0;
            want_seq   = '0;
            errors     = 0;
        endfunction

        function int pending();
            return pending_segments.size();
        endfunction

        // Work out the result of one accepted frame and queue it.
        function void note_frame(t_frame f);
            logic [3:0]  kind;
            logic [3:0]  low;
            logic [3:0]  lim;
            logic [3:0]  n;
            int unsigned sum;
            t_result     r;
            r    = '0;
            kind = f.data[0][7:4];
            low  = f.data[0][3:0];
            case (kind)
                PCI_SINGLE: begin
                    lim = (f.frame_length == 4'd0) ? 4'd0 : f.frame_length - 4'd1;
                    n   = (low > lim) ? lim : low;
                    if (n > 4'd7) begin
                        n = 4'd7;
                    end
                    r.event_res            = EV_SINGLE;
                    r.payload.byte_count   = n[CNT_W-1:0];
                    for (int i = 0; i < SEG_BYTES; i++) begin
                        if (i < n) begin
                            r.payload.seg[i] = f.data[i+1];
                        end
                    end
                    r.message_done         = 1'b1;
                    r.payload.total_length = {8'd0, n};
                end
                PCI_FIRST: begin
                    msg_total  = {low, f.data[1]};
                    bytes_seen = 13'd6;
                    want_seq   = 4'd1;
                    r.event_res            = EV_FIRST_FC;
                    r.payload.byte_count   = 3'd6;
                    for (int i = 0; i < 6; i++) begin
                        r.payload.seg[i] = f.data[i+2];
                    end
                    r.payload.total_length = msg_total;
                end
                PCI_CONSECUTIVE: begin
                    if (low != want_seq) begin
                        // drop the message, keep the expected sequence
                        msg_total  = '0;
                        bytes_seen = '0;
                        r.event_res      = EV_SEQ_ERR;
                        r.payload.seg[0] = f.data[0];
                    end else begin
                        want_seq = (want_seq == 4'hF) ? 4'd1 : want_seq + 4'd1;
                        r.payload.offset = bytes_seen;
                        sum = bytes_seen + 7;
                        bytes_seen = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
                        r.event_res            = EV_SEGMENT;
                        r.payload.byte_count   = 3'd7;
                        for (int i = 0; i < SEG_BYTES; i++) begin
                            r.payload.seg[i] = f.data[i+1];
                        end
                        r.message_done         = (bytes_seen >= {1'b0, msg_total});
                        r.payload.total_length = msg_total;
                    end
                end
                default: begin
                    r.event_res = EV_IGNORED;
                end
            endcase
            pending_segments.push_back(r);
        endfunction

        function void compare_field(string what, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            end
        endfunction

        // Check one accepted result against the oldest expectation.
        function void check_segment(t_result got, logic [3:0] pad);
            t_result want;
            if (pending_segments.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_segments.pop_front();
            compare_field("event_res", want.event_res, got.event_res);
            compare_field("offset", want.payload.offset, got.payload.offset);
            compare_field("byte_count", want.payload.byte_count, got.payload.byte_count);
            for (int i = 0; i < SEG_BYTES; i++) begin
                compare_field($sformatf("seg%0d", i), want.payload.seg[i], got.payload.seg[i]);
            end
            compare_field("message_done", want.message_done, got.message_done);
            compare_field("total_length", want.payload.total_length,
                          got.payload.total_length);
            compare_field("tdata pad", 4'd0, pad);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [EVENT_W-1:0]     o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    segment_scoreboard sb = new();
    int unsigned idle_pct = 0;      // chance per cycle that the sender holds off
    int unsigned stall_pct = 0;     // chance per cycle that the receiver stalls
    int unsigned sent_frames = 0;

    can_transport_frame_reassembler_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: drop ready at random while a stall phase is active.
    always @(negedge i_clk) begin
        i_m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // Result monitor: check every item taken off the master side.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_segment(t_result'({o_m_axis_tuser, o_m_axis_tlast,
                                        o_m_axis_tdata[$bits(t_payload)-1:0]}),
                             o_m_axis_tdata[OUT_TDATA_W-1:$bits(t_payload)]);
        end
    end

    // Build a frame with random data bytes and a legal length.
    function automatic t_frame random_frame(logic [7:0] b0);
        t_frame f;
        for (int i = 1; i < FRAME_BYTES; i++) begin
            f.data[i] = 8'($urandom);
        end
        f.data[0]      = b0;
        f.frame_length = 4'($urandom_range(0, 8));
        return f;
    endfunction

    // Build a frame whose data bytes all carry one fill value.
    function automatic t_frame fixed_frame(logic [7:0] b0, logic [7:0] fill,
                                           logic [3:0] flen);
        t_frame f;
        for (int i = 1; i < FRAME_BYTES; i++) begin
            f.data[i] = fill;
        end
        f.data[0]      = b0;
        f.frame_length = flen;
        return f;
    endfunction

    // Present one frame at the falling edge, hold it until the handshake,
    // and note it with the scoreboard. Return at the next falling edge
    // with tvalid still high so back-to-back items stay back to back.
    task automatic send_frame(input t_frame f);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W - $bits(t_frame)){1'b0}}, f};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        sb.note_frame(f);
        sent_frames++;
        @(negedge i_clk);
    endtask

    // Hold the sender off until every expected result has come back.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // One multi-frame message: first frame, then in-order consecutive
    // frames with random content. Occasionally interleave other frames,
    // send one segment too many or too few, or break the sequence.
    task automatic send_message();
        int unsigned total;
        int unsigned segs;
        int unsigned err_at;
        logic [3:0]  seq;
        t_frame      f;
        total = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095)
                                             : $urandom_range(0, 120);
        segs  = (total > 6) ? (total - 6 + 6) / 7 : 0;
        if (segs > 24) begin
            segs = 24;
        end
        case ($urandom_range(0, 7))
            0: segs = segs + 1;
            1: segs = (segs > 0) ? segs - 1 : 0;
            default: ;
        endcase
        err_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, segs) : segs + 1;
        f = random_frame({PCI_FIRST, 4'(total >> 8)});
        f.data[1] = 8'(total);
        send_frame(f);
        seq = 4'd1;
        for (int i = 0; i < segs; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_frame(random_frame({4'($urandom_range(0, 15)), 4'($urandom)}));
            end
            if (i == err_at) begin
                send_frame(random_frame({PCI_CONSECUTIVE,
                                         seq + 4'($urandom_range(1, 15))}));
                if ($urandom_range(0, 1) == 0) begin
                    break;
                end
            end else begin
                send_frame(random_frame({PCI_CONSECUTIVE, seq}));
                seq = (seq == 4'hF) ? 4'd1 : seq + 4'd1;
            end
        end
    endtask

    // Random traffic under one idling setting, then drain.
    task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned count);
        int unsigned start;
        int unsigned pick;
        idle_pct  = idle;
        stall_pct = stall;
        start     = sent_frames;
        while (sent_frames - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_message();
            end else if (pick < 75) begin
                send_frame(random_frame({PCI_SINGLE, 4'($urandom)}));
            end else if (pick < 87) begin
                send_frame(random_frame({4'($urandom_range(3, 15)), 4'($urandom)}));
            end else begin
                send_frame(random_frame(8'($urandom)));
            end
        end
        drain_results();
    endtask

    // Watchdog: give up well past the slowest legal run.
    initial begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        // hold reset, then release at a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, no idling.
        // Consecutive frame with sequence 0 straight after reset is taken.
        send_frame(fixed_frame({PCI_CONSECUTIVE, 4'h0}, 8'hFF, 4'd8));
        // Expected sequence is now 1: this one is a sequence error.
        send_frame(fixed_frame({PCI_CONSECUTIVE, 4'h7}, 8'h00, 4'd0));
        // Single frames: full payload, clamp to seven, zero and short lengths.
        send_frame(fixed_frame({PCI_SINGLE, 4'h7}, 8'hFF, 4'd8));
        send_frame(fixed_frame({PCI_SINGLE, 4'hF}, 8'h00, 4'd8));
        send_frame(fixed_frame({PCI_SINGLE, 4'h5}, 8'hFF, 4'd0));
        send_frame(fixed_frame({PCI_SINGLE, 4'h5}, 8'hFF, 4'd3));
        send_frame(fixed_frame({PCI_SINGLE, 4'h0}, 8'hFF, 4'd1));
        // Flow control and unknown types are ignored.
        send_frame(fixed_frame(8'h30, 8'hFF, 4'd3));
        send_frame(fixed_frame(8'hFF, 8'hFF, 4'd8));
        send_frame(fixed_frame(8'h80, 8'h00, 4'd0));
        // Largest declared total, then a gap in the sequence, then resume:
        // the resumed frame completes at once since the total was cleared.
        send_frame(fixed_frame({PCI_FIRST, 4'hF}, 8'hFF, 4'd8));
        send_frame(fixed_frame({PCI_CONSECUTIVE, 4'h1}, 8'h00, 4'd8));
        send_frame(fixed_frame({PCI_CONSECUTIVE, 4'h3}, 8'hFF, 4'd8));
        send_frame(fixed_frame({PCI_CONSECUTIVE, 4'h2}, 8'hFF, 4'd8));
        // Short message: first frame alone does not complete it; every later
        // segment flags completion again.
        send_frame(fixed_frame({PCI_FIRST, 4'h0}, 8'h05, 4'd8));
        send_frame(fixed_frame({PCI_CONSECUTIVE, 4'h1}, 8'hFF, 4'd8));
        send_frame(fixed_frame({PCI_CONSECUTIVE, 4'h2}, 8'h00, 4'd2));
        // Zero declared total, then an error with the highest sequence nibble.
        send_frame(fixed_frame({PCI_FIRST, 4'h0}, 8'h00, 4'd0));
        send_frame(fixed_frame({PCI_CONSECUTIVE, 4'h1}, 8'h00, 4'd0));
        send_frame(fixed_frame({PCI_CONSECUTIVE, 4'hF}, 8'hFF, 4'd8));
        drain_results();

        // Random part: no idling, then heavy sender gaps, heavy receiver
        // stalls, and light idling on both sides. Drain between phases.
        run_phase(0, 0, 130);
        run_phase(80, 0, 130);
        run_phase(0, 80, 130);
        run_phase(18, 18, 130);

        // let any stray result surface before the verdict
        stall_pct = 0;
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/ctfr_pkg.sv
design/ctfr_in_stage.sv
design/ctfr_decode.sv
design/can_transport_frame_reassembler_unit.sv
design/ctfr_checker.sv
verif/testbench.sv
